>>> rtl/lfs_pkg.sv
// Shared constants, types and helpers for the line-follow PD steering core.
package lfs_pkg;

  // Sensor array and sample geometry
  localparam int SENSOR_COUNT    = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int IDX_W           = $clog2(SENSOR_COUNT);
  localparam int CNT_W           = $clog2(SENSOR_COUNT + 1);
  localparam int WEIGHT_MAX      = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
  localparam int WEIGHT_W        = $clog2(WEIGHT_MAX + 1);

  // Position scaling and divider width
  localparam int POS_SCALE = 1000;
  localparam int DIV_W     = $clog2(WEIGHT_MAX * POS_SCALE + 1);
  localparam int STEP_W    = $clog2(DIV_W);

  // Register field widths
  localparam int THR_W      = 12;
  localparam int SET_W      = 13;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(550);
  localparam logic [SET_W-1:0]   SET_RST   = SET_W'(3500);
  localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(524);
  localparam logic [GAIN_W-1:0]  KD_RST    = GAIN_W'(39);
  localparam logic [SPEED_W-1:0] BASE_RST  = SPEED_W'(24576);
  localparam logic [SPEED_W-1:0] LIMIT_RST = SPEED_W'(24576);

  // Error and PD arithmetic widths
  localparam int ERR_W    = 14;
  localparam int ERR_MAX  = 8191;
  localparam int ERR_MIN  = -8192;
  localparam int E_WIDE_W = DIV_W + 2;
  localparam int DE_W     = ERR_W + 1;
  localparam int OPA_W    = GAIN_W + 1;
  localparam int PROD_W   = OPA_W + DE_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int FRAC_DROP = 4;
  localparam int OFS_W    = ACC_W - FRAC_DROP;
  localparam int SPD_W    = OFS_W + 1;

  // Result widths
  localparam int OUT_W = 16;
  localparam int PAT_W = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IR_THRESHOLD      = 3'd0,
    REG_POSITION_SETPOINT = 3'd1,
    REG_PROP_GAIN         = 3'd2,
    REG_DERIV_GAIN        = 3'd3,
    REG_BASE_SPEED        = 3'd4,
    REG_SPEED_LIMIT       = 3'd5
  } lfs_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_POS,
    S_DIV,
    S_ERR,
    S_MULP,
    S_MULD,
    S_ACC,
    S_OUT
  } lfs_state_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } lfs_mac_ctrl_t;

  // Clamp a wide signed speed to [-lim, +lim] and narrow it to the result width
  function automatic logic signed [OUT_W-1:0] clamp_speed(
    input logic signed [SPD_W-1:0] v,
    input logic signed [SPD_W-1:0] lim
  );
    logic signed [SPD_W-1:0] r;
    begin
      r = v;
      if (v > lim) r = lim;
      if (v < -lim) r = -lim;
      return r[OUT_W-1:0];
    end
  endfunction

endpackage

>>> rtl/line_follow_pd_steering_core.sv
// Top level: sequencer, configuration registers and result register of the steering core.
//
// Usage: a sensor frame of eight samples is offered on in_valid with the
// in_sample_* fields and taken at a clock edge where in_stall is low. The
// core stalls the input while it works on one frame, one step at a time:
// one comparator scans the sensors (one per cycle), a restoring divider
// forms the line position (one quotient bit per cycle), and one shared
// multiplier forms the two PD products in turn. A result beat appears on
// out_valid once the frame is done; when no sensor sees the line, the core
// skips the divider and the multiplier. The core is ready for the next
// frame as soon as the result beat appears. The time per frame is set by
// the sensor scan and the divider (DIV_W steps). The result sits in an
// output register; while out_stall holds it, the core finishes the next
// frame and then waits to load it. Registers are written on the cfg_
// channel (always ready); the user must write them only while the core is
// idle, as the core itself does not enforce this. Reset restores the
// register defaults, clears the stored last error and empties the output
// register.
module line_follow_pd_steering_core #(
  parameter int SAMPLE_BITS = lfs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sensor frame channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              in_sample_0,
  input  logic [SAMPLE_BITS-1:0]              in_sample_1,
  input  logic [SAMPLE_BITS-1:0]              in_sample_2,
  input  logic [SAMPLE_BITS-1:0]              in_sample_3,
  input  logic [SAMPLE_BITS-1:0]              in_sample_4,
  input  logic [SAMPLE_BITS-1:0]              in_sample_5,
  input  logic [SAMPLE_BITS-1:0]              in_sample_6,
  input  logic [SAMPLE_BITS-1:0]              in_sample_7,
  // Steering result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lfs_pkg::OUT_W-1:0]    out_left_speed,
  output logic signed [lfs_pkg::OUT_W-1:0]    out_right_speed,
  output logic [lfs_pkg::PAT_W-1:0]           out_line_pattern,
  output logic                                out_line_lost,
  output logic signed [lfs_pkg::ERR_W-1:0]    out_position_error,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lfs_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  // Configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [SET_W-1:0]   setpoint_r;
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  kd_r;
  logic [SPEED_W-1:0] base_r;
  logic [SPEED_W-1:0] limit_r;

  // Sequencer and working registers
  lfs_state_t               state_r, state_nxt;
  logic [SAMPLE_BITS-1:0]   samp_r [SENSOR_COUNT];
  logic [IDX_W-1:0]         idx_r;
  logic [CNT_W-1:0]         count_r;
  logic [WEIGHT_W-1:0]      weight_r;
  logic [PAT_W-1:0]         pattern_r;
  logic                     lost_r;
  logic signed [ERR_W-1:0]  e_r;
  logic signed [DE_W-1:0]   de_r;
  logic signed [ERR_W-1:0]  prev_err_r;

  // Result register
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  left_r;
  logic signed [OUT_W-1:0]  right_r;
  logic [PAT_W-1:0]         pat_out_r;
  logic                     lost_out_r;
  logic signed [ERR_W-1:0]  err_out_r;

  // Control strobes
  logic          in_accept;
  logic          div_start;
  logic          div_done;
  logic          out_load;
  lfs_mac_ctrl_t mac_ctrl;

  // Datapath nets
  logic                       hit;
  logic [DIV_W-1:0]           dividend;
  logic [DIV_W-1:0]           quotient;
  logic signed [E_WIDE_W-1:0] e_wide;
  logic signed [ERR_W-1:0]    e_sat;
  logic signed [DE_W-1:0]     de;
  logic signed [OPA_W-1:0]    mac_a;
  logic signed [DE_W-1:0]     mac_b;
  logic signed [ACC_W-1:0]    acc;
  logic signed [OFS_W-1:0]    offset;
  logic signed [SPD_W-1:0]    base_ext;
  logic signed [SPD_W-1:0]    lim_ext;
  logic signed [SPD_W-1:0]    ofs_ext;

  localparam logic signed [E_WIDE_W-1:0] E_HI = E_WIDE_W'(ERR_MAX);
  localparam logic signed [E_WIDE_W-1:0] E_LO = E_WIDE_W'(ERR_MIN);

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RST;
      setpoint_r <= SET_RST;
      kp_r       <= KP_RST;
      kd_r       <= KD_RST;
      base_r     <= BASE_RST;
      limit_r    <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IR_THRESHOLD:      thr_r      <= cfg_data[THR_W-1:0];
        REG_POSITION_SETPOINT: setpoint_r <= cfg_data[SET_W-1:0];
        REG_PROP_GAIN:         kp_r       <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:        kd_r       <= cfg_data[GAIN_W-1:0];
        REG_BASE_SPEED:        base_r     <= cfg_data[SPEED_W-1:0];
        REG_SPEED_LIMIT:       limit_r    <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and step strobes
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    mac_ctrl  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == IDX_W'(SENSOR_COUNT - 1)) state_nxt = S_POS;
      end
      S_POS: begin
        if (count_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ERR;
      end
      S_ERR: begin
        state_nxt = S_MULP;
      end
      S_MULP: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.acc_add = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Threshold the sensor at the head of the shift line
  assign hit = (CMP_W'(samp_r[0]) > CMP_W'(thr_r));

  // Capture the frame, then scan it one sensor per cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      samp_r[0] <= in_sample_0;
      samp_r[1] <= in_sample_1;
      samp_r[2] <= in_sample_2;
      samp_r[3] <= in_sample_3;
      samp_r[4] <= in_sample_4;
      samp_r[5] <= in_sample_5;
      samp_r[6] <= in_sample_6;
      samp_r[7] <= in_sample_7;
      idx_r     <= '0;
      count_r   <= '0;
      weight_r  <= '0;
      pattern_r <= '0;
    end else if (state_r == S_SCAN) begin
      for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
        samp_r[i] <= samp_r[i+1];
      end
      pattern_r <= {hit, pattern_r[PAT_W-1:1]};
      count_r   <= count_r + CNT_W'(hit);
      weight_r  <= hit ? weight_r + WEIGHT_W'(idx_r) : weight_r;
      idx_r     <= idx_r + IDX_W'(1);
    end
  end

  // Position = weight * 1000 / count
  assign dividend = DIV_W'(32'(weight_r) * POS_SCALE);

  lfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Error against the setpoint, saturated to the stored width
  assign e_wide = $signed({2'b00, quotient})
                - $signed({{(E_WIDE_W - SET_W){1'b0}}, setpoint_r});

  always_comb begin
    if (e_wide > E_HI) begin
      e_sat = E_HI[ERR_W-1:0];
    end else if (e_wide < E_LO) begin
      e_sat = E_LO[ERR_W-1:0];
    end else begin
      e_sat = e_wide[ERR_W-1:0];
    end
  end

  assign de = $signed({e_sat[ERR_W-1], e_sat}) - $signed({prev_err_r[ERR_W-1], prev_err_r});

  // Line-lost flag and error terms
  always_ff @(posedge clk) begin
    if (state_r == S_POS) begin
      lost_r <= (count_r == '0);
    end
    if (state_r == S_ERR) begin
      e_r  <= e_sat;
      de_r <= de;
    end
  end

  // Last error: update only when the line is seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (state_r == S_ERR) begin
      prev_err_r <= e_sat;
    end
  end

  // Operand select for the shared multiplier: Kp*e, then Kd*de
  always_comb begin
    if (state_r == S_MULP) begin
      mac_a = $signed({1'b0, kp_r});
      mac_b = $signed({e_r[ERR_W-1], e_r});
    end else begin
      mac_a = $signed({1'b0, kd_r});
      mac_b = de_r;
    end
  end

  lfs_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // Offset in signed Q29.0, in base-speed units: floor of the sum over 16, zero when the line is lost
  assign offset   = lost_r ? '0 : acc[ACC_W-1:FRAC_DROP];
  assign ofs_ext  = {offset[OFS_W-1], offset};
  assign base_ext = $signed({{(SPD_W - SPEED_W){1'b0}}, base_r});
  assign lim_ext  = $signed({{(SPD_W - SPEED_W){1'b0}}, limit_r});

  // Output register: free when empty or when its beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_r     <= clamp_speed(base_ext - ofs_ext, lim_ext);
      right_r    <= clamp_speed(base_ext + ofs_ext, lim_ext);
      pat_out_r  <= pattern_r;
      lost_out_r <= lost_r;
      err_out_r  <= lost_r ? '0 : e_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_speed     = left_r;
  assign out_right_speed    = right_r;
  assign out_line_pattern   = pat_out_r;
  assign out_line_lost      = lost_out_r;
  assign out_position_error = err_out_r;

endmodule

>>> rtl/lfs_div.sv
// Restoring divider, one quotient bit per cycle, for the line position.
module lfs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lfs_pkg::DIV_W-1:0] dividend,
  input  logic [lfs_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [lfs_pkg::DIV_W-1:0] quotient
);
  import lfs_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    shifted;
  logic              ge;

  // Bring down the next dividend bit and trial-subtract the divisor
  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});

  // Control: run DIV_W steps after start, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
      step_r <= '0;
    end else if (busy_r) begin
      q_r    <= {q_r[DIV_W-2:0], ge};
      rem_r  <= ge ? CNT_W'(shifted - {1'b0, dvs_r}) : shifted[CNT_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/lfs_mac.sv
// Shared multiplier with registered product and accumulator for the PD term.
module lfs_mac (
  input  logic                               clk,
  input  lfs_pkg::lfs_mac_ctrl_t             ctrl,
  input  logic signed [lfs_pkg::OPA_W-1:0]   op_a,
  input  logic signed [lfs_pkg::DE_W-1:0]    op_b,
  output logic signed [lfs_pkg::ACC_W-1:0]   acc
);
  import lfs_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {prod_r[PROD_W-1], prod_r};

  // Register the product; load or add the registered product into the accumulator in the next cycle
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctrl.acc_load) begin
      acc_r <= prod_ext;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  assign acc = acc_r;

endmodule
